@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rounded-corner mask rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst, pre, post, msg)

`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg)

`endif

`endif

@@ hw/rtl/rca_pkg.sv @@
// types, widths and constants of the rounded-corner alpha mask
package rca_pkg;

   localparam int MAX_SIZE_DEF = 1024;

   localparam int IMG_W   = 11;
   localparam int RAD_W   = 18;
   localparam int COORD_W = 10;
   localparam int CH_W    = 8;
   localparam int FRAC    = 8;

   // per-axis excess is below x_q8 + r, so under 2^19
   localparam int EXC_W      = 19;
   localparam int SQ_W       = 2 * EXC_W + 2;
   localparam int SQRT_STEPS = SQ_W / 2;
   localparam int ROOT_W     = SQRT_STEPS;

   localparam int RAMP_Q8     = 384;
   localparam int RAMP_W      = 9;
   // floor(v * 256 / 384) == (v * 1366) >> 11 for v below 384
   localparam int ALPHA_RECIP = 1366;
   localparam int RECIP_W     = 11;
   localparam int ALPHA_SHIFT = 11;

   localparam logic [IMG_W-1:0] SIZE_RESET   = IMG_W'(256);
   localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(13107);

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [1:0] {
      CLS_COPY = 2'd0,
      CLS_RAMP = 2'd1,
      CLS_ZERO = 2'd2
   } class_type;

   typedef enum logic [0:0] {
      CSR_IMAGE_SIZE    = 1'b0,
      CSR_CORNER_RADIUS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] alpha;
   } pix_type;

   typedef struct packed {
      logic [SQ_W-1:0] rem;
      logic [SQ_W-1:0] res;
      pix_type         pix;
   } root_link_type;

endpackage

@@ hw/rtl/rca_prep.sv @@
// front stages: corner excess per axis, squares and their sum
module rca_prep #(
   parameter int MAX_SIZE = rca_pkg::MAX_SIZE_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [rca_pkg::IMG_W-1:0]    image_size,
   input  logic [rca_pkg::RAD_W-1:0]    radius,
   input  logic                         in_valid,
   output logic                         in_adv,
   input  logic [rca_pkg::COORD_W-1:0]  pix_x,
   input  logic [rca_pkg::COORD_W-1:0]  pix_y,
   input  rca_pkg::pix_type             pix_in,
   output logic                         out_valid,
   input  logic                         out_adv,
   output rca_pkg::root_link_type       out_link
);
   import rca_pkg::*;

   localparam int SIZE_W_RAW = $clog2(MAX_SIZE + 1);
   localparam int SIZE_W     = (SIZE_W_RAW < IMG_W) ? SIZE_W_RAW : IMG_W;
   localparam int SQ8_W      = SIZE_W + FRAC;
   localparam int CMP_W      = (SQ8_W > EXC_W) ? SQ8_W : EXC_W;
   localparam int POS_W      = COORD_W + FRAC;

   function automatic logic [EXC_W-1:0] excess(input logic [POS_W-1:0] pos,
                                               input logic [SQ8_W-1:0] sq8,
                                               input logic [RAD_W-1:0] r);
      logic [CMP_W:0] pr;
      logic [CMP_W:0] sz;
      pr = (CMP_W+1)'(pos) + (CMP_W+1)'(r);
      sz = (CMP_W+1)'(sq8);
      if (pos < r) begin
         excess = EXC_W'(r - pos);
      end else if (pr > sz) begin
         excess = EXC_W'(pr - sz);
      end else begin
         excess = '0;
      end
   endfunction

   logic [SIZE_W-1:0]   size_c;
   logic [SQ8_W-1:0]    size_q8;

   logic                s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                s1_adv, s2_adv, s3_adv;
   logic [EXC_W-1:0]    dx_ff, dy_ff, dx_in, dy_in;
   pix_type             pix1_ff, pix2_ff;
   logic [2*EXC_W-1:0]  sqx_ff, sqy_ff;
   root_link_type       link_ff, link_in;

   always_comb begin
      if (int'(image_size) > MAX_SIZE) begin
         size_c = SIZE_W'(MAX_SIZE);
      end else begin
         size_c = SIZE_W'(image_size);
      end
      size_q8 = {size_c, FRAC'(0)};
      dx_in   = excess({pix_x, FRAC'(0)}, size_q8, radius);
      dy_in   = excess({pix_y, FRAC'(0)}, size_q8, radius);
      link_in.rem = SQ_W'(sqx_ff) + SQ_W'(sqy_ff);
      link_in.res = '0;
      link_in.pix = pix2_ff;
   end

   assign s3_adv = !s3_valid_ff || out_adv;
   assign s2_adv = !s2_valid_ff || s3_adv;
   assign s1_adv = !s1_valid_ff || s2_adv;
   assign in_adv = s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) s1_valid_ff <= in_valid;
         if (s2_adv) s2_valid_ff <= s1_valid_ff;
         if (s3_adv) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         pix1_ff <= pix_in;
      end
      if (s2_adv) begin
         sqx_ff  <= dx_ff * dx_ff;
         sqy_ff  <= dy_ff * dy_ff;
         pix2_ff <= pix1_ff;
      end
      if (s3_adv) begin
         link_ff <= link_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_link  = link_ff;

endmodule

@@ hw/rtl/rca_sqrt_cell.sv @@
// one digit cell of the pipelined square root chain
module rca_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_adv,
   input  rca_pkg::root_link_type  in_link,
   output logic                    out_valid,
   input  logic                    out_adv,
   output rca_pkg::root_link_type  out_link
);
   import rca_pkg::*;

   localparam logic [SQ_W-1:0] DIGIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - STEP));

   logic            valid_ff;
   logic [SQ_W-1:0] trial;
   root_link_type   link_ff, link_in;

   always_comb begin
      trial       = in_link.res + DIGIT;
      link_in.pix = in_link.pix;
      if (in_link.rem >= trial) begin
         link_in.rem = in_link.rem - trial;
         link_in.res = (in_link.res >> 1) + DIGIT;
      end else begin
         link_in.rem = in_link.rem;
         link_in.res = in_link.res >> 1;
      end
   end

   assign in_adv = !valid_ff || out_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_adv) begin
         link_ff <= link_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_link  = link_ff;

endmodule

@@ hw/rtl/rca_blend.sv @@
// back stages: classify against the radius, ramp alpha, scale and hold the result
module rca_blend (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [rca_pkg::RAD_W-1:0]     radius,
   input  logic                          in_valid,
   output logic                          in_adv,
   input  rca_pkg::root_link_type        in_link,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rca_pkg::pix_type              rsp_pix,
   output rca_pkg::class_type            rsp_class
);
   import rca_pkg::*;

   localparam int PROD_W = RAMP_W + RECIP_W;

   function automatic logic [CH_W-1:0] scale(input logic [CH_W-1:0] ch,
                                             input logic [CH_W-1:0] a);
      logic [2*CH_W-1:0] p;
      p = ch * a;
      scale = p[CH_W +: CH_W];
   endfunction

   logic [ROOT_W-1:0]  d;
   logic [ROOT_W-1:0]  lim;
   logic [RAMP_W-1:0]  ramp_in;
   class_type          cls_in;
   logic [PROD_W-1:0]  prod;

   logic               c_valid_ff, a_valid_ff, o_valid_ff;
   logic               c_adv, a_adv, o_adv;
   class_type          c_cls_ff, a_cls_ff, o_cls_ff;
   logic [RAMP_W-1:0]  ramp_ff;
   logic [CH_W-1:0]    alpha_ff;
   pix_type            c_pix_ff, a_pix_ff, o_pix_ff, o_pix_in;

   always_comb begin
      d       = in_link.res[ROOT_W-1:0];
      lim     = ROOT_W'(radius) + ROOT_W'(RAMP_Q8);
      ramp_in = '0;
      if (d > ROOT_W'(radius) && d < lim) begin
         cls_in  = CLS_RAMP;
         ramp_in = RAMP_W'(lim - d);
      end else if (d <= ROOT_W'(radius)) begin
         cls_in = CLS_COPY;
      end else begin
         cls_in = CLS_ZERO;
      end
   end

   assign prod = PROD_W'(ramp_ff) * PROD_W'(ALPHA_RECIP);

   always_comb begin
      unique case (a_cls_ff)
         CLS_COPY: begin
            o_pix_in = a_pix_ff;
         end
         CLS_RAMP: begin
            o_pix_in.red   = scale(a_pix_ff.red, alpha_ff);
            o_pix_in.green = scale(a_pix_ff.green, alpha_ff);
            o_pix_in.blue  = scale(a_pix_ff.blue, alpha_ff);
            o_pix_in.alpha = scale(a_pix_ff.alpha, alpha_ff);
         end
         default: begin
            o_pix_in = '0;
         end
      endcase
   end

   assign o_adv  = !o_valid_ff || rsp_ready;
   assign a_adv  = !a_valid_ff || o_adv;
   assign c_adv  = !c_valid_ff || a_adv;
   assign in_adv = c_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         a_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (c_adv) c_valid_ff <= in_valid;
         if (a_adv) a_valid_ff <= c_valid_ff;
         if (o_adv) o_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_adv) begin
         c_cls_ff <= cls_in;
         ramp_ff  <= ramp_in;
         c_pix_ff <= in_link.pix;
      end
      if (a_adv) begin
         a_cls_ff <= c_cls_ff;
         alpha_ff <= prod[ALPHA_SHIFT +: CH_W];
         a_pix_ff <= c_pix_ff;
      end
      if (o_adv) begin
         o_cls_ff <= a_cls_ff;
         o_pix_ff <= o_pix_in;
      end
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_pix   = o_pix_ff;
   assign rsp_class = o_cls_ff;

endmodule

@@ hw/rtl/rounded_corner_alpha_mask.sv @@
// pipeline: 3 front stages, 20 root cells and 3 back stages from req transfer to rsp
// throughput: one pixel per cycle while rsp_tready is high; one result bit per root cell
// every stage advances when empty or when the stage after it advances, so bubbles close up
// reset (synchronous, active high) empties the pipeline and loads size 256, radius 13107
// top level: csr registers, front stages, square root cell chain and blend stages
module rounded_corner_alpha_mask #(
   parameter int MAX_SIZE = rca_pkg::MAX_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // pix_x[9:0], pix_y[19:10], in_red[27:20], in_green[35:28], in_blue[43:36],
   // in_alpha[51:44], zero pad [55:52]
   input  logic [rca_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
   output logic [rca_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // pixel_class[1:0]
   output logic [1:0]                      rsp_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_we,
   input  rca_pkg::csr_index_type          csr_index,
   input  logic [rca_pkg::RAD_W-1:0]       csr_wdata
);
   import rca_pkg::*;
   `include "assert_macros.svh"

   logic [IMG_W-1:0]  image_size_ff;
   logic [RAD_W-1:0]  radius_ff;

   pix_type           req_pix;
   pix_type           rsp_pix;
   class_type         rsp_class;

   logic              chain_valid [SQRT_STEPS+1];
   logic              chain_adv   [SQRT_STEPS+1];
   root_link_type     chain_link  [SQRT_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         image_size_ff <= SIZE_RESET;
         radius_ff     <= RADIUS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_SIZE:    image_size_ff <= csr_wdata[IMG_W-1:0];
            CSR_CORNER_RADIUS: radius_ff     <= csr_wdata;
         endcase
      end
   end

   assign req_pix.red   = req_tdata[27:20];
   assign req_pix.green = req_tdata[35:28];
   assign req_pix.blue  = req_tdata[43:36];
   assign req_pix.alpha = req_tdata[51:44];

   rca_prep #(
      .MAX_SIZE (MAX_SIZE)
   ) u_prep (
      .clock      (clock),
      .reset      (reset),
      .image_size (image_size_ff),
      .radius     (radius_ff),
      .in_valid   (req_tvalid),
      .in_adv     (req_tready),
      .pix_x      (req_tdata[9:0]),
      .pix_y      (req_tdata[19:10]),
      .pix_in     (req_pix),
      .out_valid  (chain_valid[0]),
      .out_adv    (chain_adv[0]),
      .out_link   (chain_link[0])
   );

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_root
      rca_sqrt_cell #(
         .STEP (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_adv    (chain_adv[i]),
         .in_link   (chain_link[i]),
         .out_valid (chain_valid[i+1]),
         .out_adv   (chain_adv[i+1]),
         .out_link  (chain_link[i+1])
      );
   end

   rca_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .radius    (radius_ff),
      .in_valid  (chain_valid[SQRT_STEPS]),
      .in_adv    (chain_adv[SQRT_STEPS]),
      .in_link   (chain_link[SQRT_STEPS]),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_pix   (rsp_pix),
      .rsp_class (rsp_class)
   );

   assign rsp_tdata = {rsp_pix.alpha, rsp_pix.blue, rsp_pix.green, rsp_pix.red};
   assign rsp_tuser = rsp_class;

   // remainder after the last cell never exceeds twice the root
   `ASSERT_IMPLIES(a_root_rem, clock, reset, chain_valid[SQRT_STEPS], chain_link[SQRT_STEPS].rem <= (chain_link[SQRT_STEPS].res << 1), "root remainder out of range")

   // a zeroed pixel carries no colour
   `ASSERT_IMPLIES(a_zero_data, clock, reset, rsp_tvalid && rsp_class == CLS_ZERO, rsp_tdata == '0, "zeroed pixel with data")

   // input stalls only when the pipeline is backed up behind a held result
   `ASSERT_IMPLIES(a_stall_cause, clock, reset, !req_tready, rsp_tvalid && !rsp_tready, "input stalled without output back-pressure")

endmodule
